>>> rtl/owrs_pkg.sv
// Shared types and codes for the 1-Wire search ROM direction engine.
// No dependencies; used by the top level, the decision logic and the checker.
package owrs_pkg;

  // Item kinds on the input channel.
  localparam logic OP_START = 1'b0;
  localparam logic OP_PAIR  = 1'b1;

  // Bus reset outcome carried by a start word.
  localparam logic [1:0] BUS_PRESENCE = 2'd0;
  localparam logic [1:0] BUS_SHORT    = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_PROCEED  = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_FINISHED = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_NODEV    = 3'd4;
  localparam logic [2:0] ST_ERROR    = 3'd5;

  // Fork mark value that starts the search at the first address.
  localparam logic [6:0] FORK_FIRST = 7'd65;

  localparam int ADDR_OUT_W = 64;

  // Decision for one bit pair.
  typedef struct packed {
    logic dir;       // bit to write back
    logic set_fork;  // zero taken at a discrepancy: record this position
    logic err;       // both reads were one
  } owrs_dec_t;

endpackage

>>> rtl/owrs_dec.sv
// Direction decision for one bit pair of the search ROM algorithm.
// Depends on owrs_pkg for the decision struct.
module owrs_dec (
  input  logic                 read_true,
  input  logic                 read_complement,
  input  logic [6:0]           bit_pos,
  input  logic [6:0]           last_fork,
  input  logic                 prev_bit,
  output owrs_pkg::owrs_dec_t  dec
);

  always_comb begin
    dec = '0;
    if (!read_true && !read_complement) begin
      // Discrepancy: follow the previous address below the last fork,
      // take one at the fork itself, and zero beyond it.
      if (bit_pos < last_fork) begin
        dec.dir      = prev_bit;
        dec.set_fork = !prev_bit;
      end else if (bit_pos == last_fork) begin
        dec.dir = 1'b1;
      end else begin
        dec.set_fork = 1'b1;
      end
    end else if (read_true && !read_complement) begin
      dec.dir = 1'b1;
    end else if (read_true && read_complement) begin
      dec.err = 1'b1;
    end
  end

endmodule

>>> rtl/onewire_rom_search_top.sv
// Top level of the 1-Wire search ROM direction engine.
// Depends on owrs_pkg and owrs_dec.

// The engine takes one word per clock and answers every word with exactly one
// result word, in the cycle after acceptance, held in a single output register.
// A new word is taken in the same cycle that the pending result is taken, so
// the sustained rate is one word per cycle; only a stalled output channel
// slows it. A start word (tuser op 0) opens a search pass and reports
// proceed, finished, short or no device. Each bit-pair word then gets the
// direction bit to write back; the last position of the address returns
// status done with the full address. Both reads high ends the pass with a
// search error. Completed bytes are written to the address store as they
// finish, so an aborted pass leaves its finished bytes in place.
module onewire_rom_search_top #(
  parameter int ADDRESS_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] restart, [2:1] bus_status, [3] read_true, [4] read_complement, [7:5] zero
  input  logic [7:0]  in_tdata,
  // [0] op
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] direction, [64:1] address, [71:65] zero
  output logic [71:0] out_tdata,
  // [2:0] status, [3] ignored
  output logic [3:0]  out_tuser
);

  localparam logic [6:0] LAST_POS = 7'(ADDRESS_BITS);

  // Unpacked input fields.
  logic       op;
  logic       restart;
  logic [1:0] bus_status;
  logic       read_true;
  logic       read_complement;

  assign op              = in_tuser[0];
  assign restart         = in_tdata[0];
  assign bus_status      = in_tdata[2:1];
  assign read_true       = in_tdata[3];
  assign read_complement = in_tdata[4];

  // Search state.
  logic [ADDRESS_BITS-1:0] store_r, store_nxt;
  logic [6:0]              last_fork_r, last_fork_nxt;
  logic [6:0]              new_fork_r, new_fork_nxt;
  logic [6:0]              pos_r, pos_nxt;
  logic [7:0]              acc_r, acc_nxt;
  logic                    pass_r, pass_nxt;

  // Result register.
  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic        dir_r, dir_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic        ign_r, ign_nxt;

  logic accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // The store seen as a full 64-bit address so any position indexes it.
  logic [63:0] store_ext;
  logic [5:0]  idx;
  logic        prev_bit;

  always_comb begin
    store_ext = '0;
    store_ext[ADDRESS_BITS-1:0] = store_r;
  end

  assign idx      = 6'(pos_r - 7'd1);
  assign prev_bit = store_ext[idx];

  owrs_pkg::owrs_dec_t dec;

  owrs_dec u_dec (
    .read_true       (read_true),
    .read_complement (read_complement),
    .bit_pos         (pos_r),
    .last_fork       (last_fork_r),
    .prev_bit        (prev_bit),
    .dec             (dec)
  );

  logic [6:0] fork_eff;
  logic [7:0] acc_shift;
  logic [7:0] commit_val;
  logic       last_bit;
  logic       byte_end;
  logic       do_commit;

  assign acc_shift = {dec.dir, acc_r[7:1]};
  assign last_bit  = (pos_r >= LAST_POS);
  assign byte_end  = (idx[2:0] == 3'd7);
  assign do_commit = byte_end || last_bit;
  // A short last byte is right-aligned so its bits land at their positions.
  assign commit_val = byte_end ? acc_shift : (acc_shift >> (3'd7 - idx[2:0]));

  always_comb begin
    store_nxt     = store_r;
    last_fork_nxt = last_fork_r;
    new_fork_nxt  = new_fork_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    pass_nxt      = pass_r;
    status_nxt    = owrs_pkg::ST_PROCEED;
    dir_nxt       = 1'b0;
    addr_nxt      = '0;
    ign_nxt       = 1'b0;
    fork_eff      = restart ? owrs_pkg::FORK_FIRST : last_fork_r;

    if (op == owrs_pkg::OP_START) begin
      pass_nxt      = 1'b0;
      last_fork_nxt = fork_eff;
      if (fork_eff == 7'd0) begin
        status_nxt = owrs_pkg::ST_FINISHED;
      end else if (bus_status == owrs_pkg::BUS_SHORT) begin
        status_nxt = owrs_pkg::ST_SHORT;
      end else if (bus_status != owrs_pkg::BUS_PRESENCE) begin
        // The reserved code is handled like no presence.
        status_nxt = owrs_pkg::ST_NODEV;
      end else begin
        pass_nxt     = 1'b1;
        pos_nxt      = 7'd1;
        new_fork_nxt = 7'd0;
        acc_nxt      = 8'd0;
      end
    end else if (!pass_r) begin
      ign_nxt = 1'b1;
    end else if (dec.err) begin
      pass_nxt   = 1'b0;
      status_nxt = owrs_pkg::ST_ERROR;
    end else begin
      dir_nxt = dec.dir;
      if (dec.set_fork) begin
        new_fork_nxt = pos_r;
      end
      acc_nxt = acc_shift;
      if (do_commit) begin
        acc_nxt = 8'd0;
        for (int i = 0; i < ADDRESS_BITS; i++) begin
          if (3'(i >> 3) == idx[5:3]) begin
            store_nxt[i] = commit_val[3'(i)];
          end
        end
      end
      if (last_bit) begin
        last_fork_nxt = new_fork_nxt;
        pass_nxt      = 1'b0;
        status_nxt    = owrs_pkg::ST_DONE;
        addr_nxt[ADDRESS_BITS-1:0] = store_nxt;
      end else begin
        pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r     <= '0;
      last_fork_r <= owrs_pkg::FORK_FIRST;
      new_fork_r  <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        store_r     <= store_nxt;
        last_fork_r <= last_fork_nxt;
        new_fork_r  <= new_fork_nxt;
        pos_r       <= pos_nxt;
        acc_r       <= acc_nxt;
        pass_r      <= pass_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      dir_r    <= dir_nxt;
      addr_r   <= addr_nxt;
      ign_r    <= ign_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, addr_r, dir_r};
  assign out_tuser  = {ign_r, status_r};

endmodule

>>> rtl/owrs_chk.sv
// Port-level checker for the 1-Wire search ROM direction engine, with its bind.
// Depends on owrs_pkg for the status codes.
module owrs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // A result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // The address is shown only with a finished address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] != owrs_pkg::ST_DONE |-> out_tdata[64:1] == 64'd0)
    else $error("address present without done status");

  // A direction bit only comes with a bit-pair proceed or done result.
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] != owrs_pkg::ST_PROCEED
      && out_tuser[2:0] != owrs_pkg::ST_DONE |-> !out_tdata[0])
    else $error("direction set on a non-proceed result");

  // An ignored pair answers plain proceed with direction zero.
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == owrs_pkg::ST_PROCEED && !out_tdata[0])
    else $error("ignored pair with unexpected status or direction");

endmodule

bind onewire_rom_search_top owrs_chk u_owrs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> test/onewire_search_checker.sv
// Checker for the 1-Wire search ROM direction engine: watches both stream channels,
// predicts each result word from the accepted input words and compares field by field.
// Depends on owrs_pkg for the operation, bus status and result status codes.
module onewire_search_checker #(
  parameter int ADDRESS_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [3:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          addresses_found,
  output int          searches_finished
);

  typedef struct packed {
    logic [2:0]  status;
    logic        dir;
    logic [63:0] address;
    logic        ignored;
  } search_result_t;

  search_result_t expected_q[$];
  search_result_t want;
  search_result_t got;

  // Predicted engine state.
  logic [63:0] rom_store;
  logic [6:0]  last_fork;
  logic [6:0]  new_fork;
  logic [6:0]  bit_pos;
  logic [7:0]  byte_acc;
  logic        in_pass;

  int fails;
  int n_checked;
  int n_found;
  int n_finished;

  initial begin
    fails = 0;
    n_checked = 0;
    n_found = 0;
    n_finished = 0;
  end

  task automatic decide_direction(input logic op, input logic restart, input logic [1:0] bus,
                                  input logic rt, input logic rc, output search_result_t res);
    logic [6:0] p;
    logic [5:0] idx;
    logic [2:0] in_byte;
    logic       d;
    res = '0;
    if (op == owrs_pkg::OP_START) begin
      in_pass = 1'b0;
      if (restart) last_fork = owrs_pkg::FORK_FIRST;
      if (last_fork == 7'd0) begin
        res.status = owrs_pkg::ST_FINISHED;
      end else if (bus == owrs_pkg::BUS_SHORT) begin
        res.status = owrs_pkg::ST_SHORT;
      end else if (bus != owrs_pkg::BUS_PRESENCE) begin
        res.status = owrs_pkg::ST_NODEV;
      end else begin
        in_pass = 1'b1;
        bit_pos = 7'd1;
        new_fork = 7'd0;
        byte_acc = 8'd0;
        res.status = owrs_pkg::ST_PROCEED;
      end
    end else if (!in_pass) begin
      res.status = owrs_pkg::ST_PROCEED;
      res.ignored = 1'b1;
    end else if (rt && rc) begin
      // Nobody answered either slot: the pass ends, the fork mark stays.
      in_pass = 1'b0;
      res.status = owrs_pkg::ST_ERROR;
    end else begin
      p = bit_pos;
      idx = 6'(p - 7'd1);
      d = 1'b0;
      if (!rt && !rc) begin
        // Discrepancy: below the fork follow the old address, at the fork take
        // the one branch, above it take zero. Zero taken marks a new fork.
        if (p < last_fork) begin
          if (rom_store[idx]) d = 1'b1;
          else new_fork = p;
        end else if (p == last_fork) begin
          d = 1'b1;
        end else begin
          new_fork = p;
        end
      end else if (rt && !rc) begin
        d = 1'b1;
      end
      byte_acc = {d, byte_acc[7:1]};
      in_byte = idx[2:0];
      if (in_byte == 3'd7) begin
        rom_store[idx[5:3]*8 +: 8] = byte_acc;
        byte_acc = 8'd0;
      end else if (p >= ADDRESS_BITS) begin
        rom_store[idx[5:3]*8 +: 8] = byte_acc >> (3'd7 - in_byte);
        byte_acc = 8'd0;
      end
      res.dir = d;
      if (p >= ADDRESS_BITS) begin
        last_fork = new_fork;
        in_pass = 1'b0;
        res.status = owrs_pkg::ST_DONE;
        res.address = rom_store;
      end else begin
        bit_pos = p + 7'd1;
        res.status = owrs_pkg::ST_PROCEED;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rom_store = '0;
      last_fork = owrs_pkg::FORK_FIRST;
      new_fork = '0;
      bit_pos = '0;
      byte_acc = '0;
      in_pass = 1'b0;
      expected_q.delete();
    end else begin
      // The result taken at this edge belongs to a word taken at an earlier
      // edge, so compare first and predict the new word afterwards.
      if (out_tvalid && out_tready) begin
        got.status = out_tuser[2:0];
        got.ignored = out_tuser[3];
        got.dir = out_tdata[0];
        got.address = out_tdata[64:1];
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected, got status %0d", $time, got.status);
          fails++;
        end else begin
          want = expected_q.pop_front();
          compare_field("status", 64'(want.status), 64'(got.status));
          compare_field("direction", 64'(want.dir), 64'(got.dir));
          compare_field("address", want.address, got.address);
          compare_field("ignored", 64'(want.ignored), 64'(got.ignored));
          compare_field("tdata padding", 64'd0, 64'(out_tdata[71:65]));
          n_checked++;
          if (want.status == owrs_pkg::ST_DONE) n_found++;
          if (want.status == owrs_pkg::ST_FINISHED) n_finished++;
        end
      end
      if (in_tvalid && in_tready) begin
        decide_direction(in_tuser[0], in_tdata[0], in_tdata[2:1], in_tdata[3], in_tdata[4],
                         want);
        expected_q.push_back(want);
      end
    end
    fail_count <= fails;
    pending <= expected_q.size();
    checked <= n_checked;
    addresses_found <= n_found;
    searches_finished <= n_finished;
  end

endmodule

>>> test/tb_onewire_rom_search_top.sv
// Testbench top for the 1-Wire search ROM direction engine: clock, reset, stimulus,
// output back-pressure, watchdog and the final verdict.
// Depends on owrs_pkg, onewire_rom_search_top and onewire_search_checker.
module tb_onewire_rom_search_top;

  // Bus outcomes that the package does not name: no presence pulse, and the
  // reserved code that the engine must treat the same way.
  localparam logic [1:0] BUS_ABSENT   = 2'd2;
  localparam logic [1:0] BUS_RESERVED = 2'd3;

  // Cycles without any word moving on either channel before the run is
  // declared hung. Every word is answered in the cycle after it is taken and
  // stalls are short, so a healthy run never gets anywhere near this.
  localparam int STALL_LIMIT = 1000;

  // No new stimulus batch starts once this many words have gone in.
  localparam int WORD_TARGET = 1750;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [0] restart, [2:1] bus_status, [3] read_true, [4] read_complement, [7:5] zero
  logic [7:0]  in_tdata = 8'd0;
  // [0] op
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] direction, [64:1] address, [71:65] zero
  logic [71:0] out_tdata;
  // [2:0] status, [3] ignored
  logic [3:0]  out_tuser;

  int fail_count;
  int pending;
  int checked;
  int addresses_found;
  int searches_finished;

  // Words sent so far, and result words seen; the device search below waits for
  // each direction bit before it can work out the next pair of read slots.
  int         words_sent = 0;
  int         results_seen = 0;
  logic       last_dir = 1'b0;
  logic [2:0] last_status = owrs_pkg::ST_PROCEED;
  int         idle_cycles = 0;

  // While quiet is set neither side inserts gaps, so the engine runs flat out.
  logic quiet = 1'b0;

  onewire_rom_search_top #(
    .ADDRESS_BITS(64)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  onewire_search_checker #(
    .ADDRESS_BITS(64)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tuser          (in_tuser),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tuser         (out_tuser),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked),
    .addresses_found   (addresses_found),
    .searches_finished (searches_finished)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver drops ready about 7 percent of the time, except in the quiet
  // stretch.
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 7);
  end

  // Track what comes back so the device search can follow the chosen branch.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      last_dir <= out_tdata[0];
      last_status <= out_tuser[2:0];
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
          $display("** onewire_rom_search_top: FAILED **");
          $finish;
        end
      end
    end
  end

  // Presents one word and holds it until the engine takes it. A one-cycle gap
  // may come first; valid is only lowered when such a gap is inserted, so it
  // is never dropped and raised again within one time step.
  task automatic send_word(input logic op, input logic restart, input logic [1:0] bus,
                           input logic rt, input logic rc);
    if (!quiet && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, rc, rt, bus, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Lets the channel go idle until the answer to the last word has been taken.
  task automatic await_result();
    in_tvalid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
  endtask

  initial begin
    int         mode;
    int         n_pairs;
    int         pass_no;
    int         b;
    int         i;
    int         n_dev;
    int         cut;
    int         r;
    int         searches;
    logic [63:0] rom [4];
    logic [3:0] live;
    logic       rt;
    logic       rc;
    logic       any_zero;
    logic       any_one;
    logic       first;
    logic       stop;
    logic       no_zero;

    searches = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Pairs before any start and after an error are strays;
    // starts go through every bus outcome, including the reserved code; a
    // start arrives in the middle of a pass; both reads high ends a pass.
    send_word(owrs_pkg::OP_PAIR, 1'b1, BUS_RESERVED, 1'b0, 1'b0);
    send_word(owrs_pkg::OP_PAIR, 1'b0, owrs_pkg::BUS_PRESENCE, 1'b1, 1'b1);
    send_word(owrs_pkg::OP_START, 1'b0, owrs_pkg::BUS_SHORT, 1'b1, 1'b1);
    send_word(owrs_pkg::OP_START, 1'b1, BUS_ABSENT, 1'b0, 1'b0);
    send_word(owrs_pkg::OP_START, 1'b0, BUS_RESERVED, 1'b1, 1'b0);
    send_word(owrs_pkg::OP_START, 1'b1, owrs_pkg::BUS_PRESENCE, 1'b0, 1'b1);
    send_word(owrs_pkg::OP_PAIR, 1'b0, owrs_pkg::BUS_PRESENCE, 1'b0, 1'b0);
    send_word(owrs_pkg::OP_PAIR, 1'b1, owrs_pkg::BUS_SHORT, 1'b0, 1'b1);
    send_word(owrs_pkg::OP_PAIR, 1'b0, BUS_RESERVED, 1'b1, 1'b0);
    send_word(owrs_pkg::OP_START, 1'b0, owrs_pkg::BUS_PRESENCE, 1'b0, 1'b0);
    send_word(owrs_pkg::OP_PAIR, 1'b0, owrs_pkg::BUS_PRESENCE, 1'b0, 1'b1);
    send_word(owrs_pkg::OP_PAIR, 1'b1, BUS_ABSENT, 1'b1, 1'b1);
    send_word(owrs_pkg::OP_PAIR, 1'b0, owrs_pkg::BUS_PRESENCE, 1'b0, 1'b0);
    send_word(owrs_pkg::OP_START, 1'b1, owrs_pkg::BUS_SHORT, 1'b0, 1'b0);

    // Random part, in three flavors:
    //   - a full device search: a small population of devices sharing random
    //     prefixes answers each read slot as real parts would, following the
    //     direction written back, until finished or an error, up to eight passes;
    //   - open-loop passes with random read slots, not waiting for results, some without
    //     any discrepancy so the fork mark drops to zero;
    //   - noise: random starts with any bus outcome and stray pairs.
    while (words_sent < WORD_TARGET) begin
      quiet <= (words_sent >= 700) && (words_sent < 1050);
      mode = $urandom_range(99);
      if (mode < 45) begin
        searches++;
        n_dev = $urandom_range(1, 4);
        rom[0] = {$urandom, $urandom};
        for (i = 1; i < 4; i++) begin
          cut = $urandom_range(63);
          rom[i] = rom[0] ^ (({$urandom, $urandom} | 64'd1) << cut);
        end
        first = 1'b1;
        stop = 1'b0;
        for (pass_no = 0; pass_no < 8 && !stop && words_sent < WORD_TARGET; pass_no++) begin
          send_word(owrs_pkg::OP_START, first, owrs_pkg::BUS_PRESENCE, $urandom_range(1),
                    $urandom_range(1));
          await_result();
          first = 1'b0;
          if (last_status != owrs_pkg::ST_PROCEED) begin
            stop = 1'b1;
          end else begin
            live = 4'b0;
            for (i = 0; i < n_dev; i++) live[i] = 1'b1;
            for (b = 0; b < 64 && !stop; b++) begin
              any_zero = 1'b0;
              any_one = 1'b0;
              for (i = 0; i < 4; i++) begin
                if (live[i] && !rom[i][b]) any_zero = 1'b1;
                if (live[i] && rom[i][b]) any_one = 1'b1;
              end
              rt = !any_zero;
              rc = !any_one;
              // Now and then a device drops off the bus mid-search.
              if ($urandom_range(999) < 3) begin
                rt = 1'b1;
                rc = 1'b1;
              end
              send_word(owrs_pkg::OP_PAIR, $urandom_range(1), $urandom_range(3), rt, rc);
              await_result();
              if (last_status == owrs_pkg::ST_ERROR) begin
                stop = 1'b1;
              end else begin
                for (i = 0; i < 4; i++) begin
                  if (rom[i][b] != last_dir) live[i] = 1'b0;
                end
              end
            end
          end
        end
      end else if (mode < 85) begin
        send_word(owrs_pkg::OP_START, $urandom_range(9) == 0, owrs_pkg::BUS_PRESENCE,
                  $urandom_range(1), $urandom_range(1));
        n_pairs = ($urandom_range(99) < 75) ? 64 : $urandom_range(1, 70);
        no_zero = $urandom_range(99) < 20;
        for (b = 0; b < n_pairs; b++) begin
          // 40% discrepancy, 30% all zero, 27% all one, 3% nobody answers.
          r = no_zero ? $urandom_range(40, 96) : $urandom_range(99);
          rt = (r >= 70);
          rc = ((r >= 40) && (r < 70)) || (r >= 97);
          send_word(owrs_pkg::OP_PAIR, $urandom_range(1), $urandom_range(3), rt, rc);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word($urandom_range(1), $urandom_range(1), $urandom_range(3), $urandom_range(1),
                    $urandom_range(1));
        end
      end
    end

    // Drain: let the checker see the last word, wait for every answer, then
    // give the registered output a comfortable margin.
    in_tvalid <= 1'b0;
    quiet <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d words, %0d closed-loop device searches and %0d checked results,",
             words_sent, searches, checked);
    $display("with %0d addresses completed and %0d searches reported as finished.",
             addresses_found, searches_finished);
    if (fail_count == 0) begin
      $display("** onewire_rom_search_top: PASSED **");
    end else begin
      $display("** onewire_rom_search_top: FAILED **");
    end
    $finish;
  end

endmodule
